// File: hw/rtl/cjtm_pkg.sv
// Shared constants, types and codes for the cron job table matcher.
`timescale 1ns / 1ps
package cjtm_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_UNLOAD = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_UNLOAD = 2'd1,
    ST_TICK   = 2'd2,
    ST_FLUSH  = 2'd3
  } state_t;

  typedef struct packed {
    logic [6:0] minute;
    logic [5:0] hour;
    logic [5:0] day;
    logic [4:0] month;
    logic [3:0] weekday;
  } sched_t;

  typedef struct packed {
    sched_t      pat;
    logic [31:0] func;
    logic [7:0]  owner;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: hw/rtl/cjtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cjtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/cjtm_match.sv
// Schedule pattern compare of one table entry against the current time.
`timescale 1ns / 1ps
module cjtm_match (
  input  cjtm_pkg::sched_t pat,
  input  cjtm_pkg::sched_t now,
  output logic             hit
);

  logic m_min, m_hour, m_day, m_mon, m_wday;

  always_comb begin
    m_min  = pat.minute[6]  || (pat.minute  == now.minute);
    m_hour = pat.hour[5]    || (pat.hour    == now.hour);
    m_day  = pat.day[5]     || (pat.day     == now.day);
    m_mon  = pat.month[4]   || (pat.month   == now.month);
    m_wday = pat.weekday[3] || (pat.weekday == now.weekday);
    hit    = m_min && m_hour && m_day && m_mon && m_wday;
  end

endmodule

// File: hw/rtl/cron_job_table_matcher.sv
// Top level of the cron job table matcher: command sequencer and table scan.
//
//   port group  direction  contents
//   in_*        request    cmd, second, minute, hour, day, month, weekday, func_id, owner_id
//   out_*       result     fired_func, fired_owner, last
//
// Add writes the entry in the idle state. Unload and a tick on second zero then scan the table one entry
// per cycle through the single read port of the table RAM; a tick then passes through a flush state
// for the final match.
// Output stalls hold the tick scan and the flush.
// After reset the table is empty; no clearing pass is needed.
// A new request is taken only when the sequencer is idle.
`timescale 1ns / 1ps
module cron_job_table_matcher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [5:0]         in_second,
  input  logic signed [6:0]  in_minute,
  input  logic signed [5:0]  in_hour,
  input  logic signed [5:0]  in_day,
  input  logic signed [4:0]  in_month,
  input  logic signed [3:0]  in_weekday,
  input  logic [31:0]        in_func_id,
  input  logic [7:0]         in_owner_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_fired_func,
  output logic [7:0]         out_fired_owner,
  output logic               out_last
);

  localparam int IDX_W = cjtm_pkg::IDX_W;
  localparam int CNT_W = cjtm_pkg::CNT_W;

  cjtm_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  keep_r, keep_nxt;
  logic              dv_r, dv_nxt;
  logic [7:0]        key_r, key_nxt;
  cjtm_pkg::sched_t  now_r, now_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [31:0]       pend_func_r, pend_func_nxt;
  logic [7:0]        pend_owner_r, pend_owner_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_func_r, out_func_nxt;
  logic [7:0]        out_owner_r, out_owner_nxt;
  logic              out_last_r, out_last_nxt;

  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  cjtm_pkg::entry_t  wdata, rdata;
  logic              match_hit;

  logic              in_acc, scan_done, issue, hit, can_push, stall, push, push_last;
  logic [CNT_W-1:0]  idx_prev;
  cjtm_pkg::cmd_t    cmd;
  cjtm_pkg::entry_t  new_entry;

  cjtm_ram #(
    .WIDTH(cjtm_pkg::ENTRY_W),
    .DEPTH(cjtm_pkg::MAX_JOBS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  cjtm_match u_match (
    .pat (rdata.pat),
    .now (now_r),
    .hit (match_hit)
  );

  always_comb begin
    cmd       = cjtm_pkg::cmd_t'(in_cmd);
    in_ready  = (state_r == cjtm_pkg::ST_IDLE);
    in_acc    = in_valid && in_ready;
    scan_done = !dv_r && (idx_r == cnt_r);
    issue     = (idx_r < cnt_r);
    hit       = dv_r && match_hit;
    can_push  = !out_valid_r || out_ready;
    stall     = (state_r == cjtm_pkg::ST_TICK) && hit && pend_v_r && !can_push;
    idx_prev  = CNT_W'(idx_r - 1'b1);

    new_entry.pat.minute  = in_minute;
    new_entry.pat.hour    = in_hour;
    new_entry.pat.day     = in_day;
    new_entry.pat.month   = in_month;
    new_entry.pat.weekday = in_weekday;
    new_entry.func        = in_func_id;
    new_entry.owner       = in_owner_id;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cjtm_pkg::ST_IDLE: begin
        if (in_acc && cmd == cjtm_pkg::CMD_UNLOAD) begin
          state_nxt = cjtm_pkg::ST_UNLOAD;
        end else if (in_acc && cmd == cjtm_pkg::CMD_TICK && in_second == 6'd0) begin
          state_nxt = cjtm_pkg::ST_TICK;
        end
      end
      cjtm_pkg::ST_UNLOAD: begin
        if (scan_done) begin
          state_nxt = cjtm_pkg::ST_IDLE;
        end
      end
      cjtm_pkg::ST_TICK: begin
        if (scan_done) begin
          state_nxt = cjtm_pkg::ST_FLUSH;
        end
      end
      cjtm_pkg::ST_FLUSH: begin
        if (!pend_v_r || can_push) begin
          state_nxt = cjtm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cjtm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    keep_nxt       = keep_r;
    dv_nxt         = dv_r;
    key_nxt        = key_r;
    now_nxt        = now_r;
    pend_v_nxt     = pend_v_r;
    pend_func_nxt  = pend_func_r;
    pend_owner_nxt = pend_owner_r;
    we             = 1'b0;
    waddr          = keep_r[IDX_W-1:0];
    wdata          = rdata;
    raddr          = idx_r[IDX_W-1:0];
    push           = 1'b0;
    push_last      = 1'b0;

    unique case (state_r)
      cjtm_pkg::ST_IDLE: begin
        idx_nxt  = '0;
        dv_nxt   = 1'b0;
        keep_nxt = '0;
        if (in_acc) begin
          key_nxt = in_owner_id;
          now_nxt = new_entry.pat;
          if (cmd == cjtm_pkg::CMD_ADD && cnt_r < CNT_W'(cjtm_pkg::MAX_JOBS)) begin
            we      = 1'b1;
            waddr   = cnt_r[IDX_W-1:0];
            wdata   = new_entry;
            cnt_nxt = CNT_W'(cnt_r + 1'b1);
          end
        end
      end
      cjtm_pkg::ST_UNLOAD: begin
        if (dv_r && rdata.owner != key_r) begin
          we       = 1'b1;
          keep_nxt = CNT_W'(keep_r + 1'b1);
        end
        dv_nxt = issue;
        if (issue) begin
          idx_nxt = CNT_W'(idx_r + 1'b1);
        end
        if (scan_done) begin
          cnt_nxt = keep_r;
        end
      end
      cjtm_pkg::ST_TICK: begin
        if (stall) begin
          raddr = idx_prev[IDX_W-1:0];
        end else begin
          if (hit) begin
            push           = pend_v_r;
            pend_v_nxt     = 1'b1;
            pend_func_nxt  = rdata.func;
            pend_owner_nxt = rdata.owner;
          end
          dv_nxt = issue;
          if (issue) begin
            idx_nxt = CNT_W'(idx_r + 1'b1);
          end
        end
      end
      cjtm_pkg::ST_FLUSH: begin
        if (pend_v_r && can_push) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    out_func_nxt  = out_func_r;
    out_owner_nxt = out_owner_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_func_nxt  = pend_func_r;
      out_owner_nxt = pend_owner_r;
      out_last_nxt  = push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cjtm_pkg::ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      keep_r      <= '0;
      dv_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      keep_r      <= keep_nxt;
      dv_r        <= dv_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    now_r        <= now_nxt;
    pend_func_r  <= pend_func_nxt;
    pend_owner_r <= pend_owner_nxt;
    out_func_r   <= out_func_nxt;
    out_owner_r  <= out_owner_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_fired_func  = out_func_r;
  assign out_fired_owner = out_owner_r;
  assign out_last        = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(cjtm_pkg::MAX_JOBS))
    else $error("job count exceeds table depth");

  a_tick_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cjtm_pkg::ST_TICK || state_r == cjtm_pkg::ST_FLUSH) |-> !we)
    else $error("table written during tick scan");

  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == cjtm_pkg::ST_TICK || state_r == cjtm_pkg::ST_FLUSH))
    else $error("pending match outside tick");

  a_keep_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cjtm_pkg::ST_UNLOAD) |-> (keep_r <= idx_r))
    else $error("compaction write overtakes read");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cjtm_pkg::ST_FLUSH && pend_v_r && can_push) |=> (out_valid && out_last))
    else $error("final match not flagged last");

endmodule

// File: test/cron_job_table_matcher_checker.sv
// Checker for the cron job table matcher: tracks the job table and compares fired jobs.
`timescale 1ns / 1ps
module cron_job_table_matcher_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [5:0]         in_second,
  input  logic signed [6:0]  in_minute,
  input  logic signed [5:0]  in_hour,
  input  logic signed [5:0]  in_day,
  input  logic signed [4:0]  in_month,
  input  logic signed [3:0]  in_weekday,
  input  logic [31:0]        in_func_id,
  input  logic [7:0]         in_owner_id,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [31:0]        out_fired_func,
  input  logic [7:0]         out_fired_owner,
  input  logic               out_last,
  output int                 err_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [31:0] func;
    logic [7:0]  owner;
    logic        last;
  } fired_job_t;

  cjtm_pkg::entry_t job_table [cjtm_pkg::MAX_JOBS];
  int               job_total = 0;
  fired_job_t       fired_q [$];
  int               mismatches = 0;

  function automatic bit sched_hit(cjtm_pkg::sched_t pat, cjtm_pkg::sched_t now);
    return (pat.minute[6]  || pat.minute  == now.minute) &&
           (pat.hour[5]    || pat.hour    == now.hour) &&
           (pat.day[5]     || pat.day     == now.day) &&
           (pat.month[4]   || pat.month   == now.month) &&
           (pat.weekday[3] || pat.weekday == now.weekday);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic apply_request(cjtm_pkg::cmd_t cmd, logic [5:0] sec, cjtm_pkg::sched_t tm,
                               logic [31:0] func, logic [7:0] owner);
    int keep;
    int hits;
    int k;
    fired_job_t f;
    case (cmd)
      cjtm_pkg::CMD_ADD: begin
        if (job_total < cjtm_pkg::MAX_JOBS) begin
          job_table[job_total] = '{pat: tm, func: func, owner: owner};
          job_total++;
        end
      end
      cjtm_pkg::CMD_UNLOAD: begin
        keep = 0;
        for (int e = 0; e < job_total; e++) begin
          if (job_table[e].owner != owner) begin
            job_table[keep] = job_table[e];
            keep++;
          end
        end
        job_total = keep;
      end
      cjtm_pkg::CMD_TICK: begin
        if (sec == 6'd0) begin
          hits = 0;
          for (int e = 0; e < job_total; e++)
            if (sched_hit(job_table[e].pat, tm)) hits++;
          k = 0;
          for (int e = 0; e < job_total; e++) begin
            if (sched_hit(job_table[e].pat, tm)) begin
              f.func = job_table[e].func;
              f.owner = job_table[e].owner;
              f.last = (k == hits - 1);
              fired_q.push_back(f);
              k++;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    fired_job_t want;
    if (!rst_n) begin
      job_total = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (fired_q.size() == 0) begin
          report_mismatch("result with nothing pending, func", out_fired_func, 32'd0);
        end else begin
          want = fired_q.pop_front();
          if (out_fired_func !== want.func)
            report_mismatch("fired_func", out_fired_func, want.func);
          if (out_fired_owner !== want.owner)
            report_mismatch("fired_owner", {24'd0, out_fired_owner}, {24'd0, want.owner});
          if (out_last !== want.last)
            report_mismatch("last", {31'd0, out_last}, {31'd0, want.last});
        end
      end
      if (in_valid && in_ready)
        apply_request(cjtm_pkg::cmd_t'(in_cmd), in_second,
                      {in_minute, in_hour, in_day, in_month, in_weekday},
                      in_func_id, in_owner_id);
    end
    pending_count <= fired_q.size();
    err_count <= mismatches;
  end

endmodule

// File: test/cron_job_table_matcher_test.sv
// Testbench top for the cron job table matcher: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module cron_job_table_matcher_test;

  localparam int               HOLD_CYCLES  = 300;
  localparam int               IDLE_LIMIT   = 5000;
  localparam int               SCAN_SLACK   = cjtm_pkg::MAX_JOBS + 8;
  localparam int               RANDOM_ITEMS = 410;
  localparam cjtm_pkg::sched_t ANY_TIME     = '1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_cmd = cjtm_pkg::CMD_NONE;
  logic [5:0]         in_second = '0;
  logic signed [6:0]  in_minute = '0;
  logic signed [5:0]  in_hour = '0;
  logic signed [5:0]  in_day = '0;
  logic signed [4:0]  in_month = '0;
  logic signed [3:0]  in_weekday = '0;
  logic [31:0]        in_func_id = '0;
  logic [7:0]         in_owner_id = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [31:0]        out_fired_func;
  logic [7:0]         out_fired_owner;
  logic               out_last;
  int                 err_count;
  int                 pending_count;

  bit hold_req = 1'b0;
  bit holding = 1'b0;
  bit no_idle = 1'b0;
  int idle_cycles = 0;

  cron_job_table_matcher u_dut (.*);

  cron_job_table_matcher_checker u_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : receiver
    int r;
    int len;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) begin
          out_ready = 1'b1;
          len = $urandom_range(1, 8);
        end else if (r < 93) begin
          out_ready = 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          out_ready = 1'b0;
          len = $urandom_range(20, 60);
        end
        repeat (len) @(negedge clk);
      end
    end
  end

  function automatic cjtm_pkg::sched_t mk_time(logic [6:0] m, logic [5:0] h, logic [5:0] d,
                                               logic [4:0] mo, logic [3:0] w);
    return {m, h, d, mo, w};
  endfunction

  function automatic logic [6:0] pick_field(bit is_pattern);
    int r;
    r = $urandom_range(0, 99);
    if (is_pattern && r < 55) return '1;
    if (r < 92) return 7'($urandom_range(0, 2));
    return 7'($urandom);
  endfunction

  function automatic cjtm_pkg::sched_t random_time(bit is_pattern);
    logic [6:0] m, h, d, mo, w;
    m = pick_field(is_pattern);
    h = pick_field(is_pattern);
    d = pick_field(is_pattern);
    mo = pick_field(is_pattern);
    w = pick_field(is_pattern);
    return mk_time(m, h[5:0], d[5:0], mo[4:0], w[3:0]);
  endfunction

  function automatic logic [7:0] pick_owner();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, 3));
    return 8'($urandom);
  endfunction

  task automatic send_req(cjtm_pkg::cmd_t cmd, logic [5:0] sec, cjtm_pkg::sched_t tm,
                          logic [31:0] func, logic [7:0] owner);
    @(negedge clk);
    in_cmd = cmd;
    in_second = sec;
    in_minute = tm.minute;
    in_hour = tm.hour;
    in_day = tm.day;
    in_month = tm.month;
    in_weekday = tm.weekday;
    in_func_id = func;
    in_owner_id = owner;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70) len = 0;
    else if (r < 95) len = $urandom_range(1, 3);
    else len = $urandom_range(10, 40);
    if (len > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (len - 1) @(negedge clk);
    end
  endtask

  task automatic drain_wait();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SCAN_SLACK) @(negedge clk);
  endtask

  initial begin : stimulus
    int sent;
    int r;
    bit paused;
    cjtm_pkg::sched_t late_time;
    late_time = mk_time(7'd59, 6'd23, 6'd31, 5'd12, 4'd6);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_req(cjtm_pkg::CMD_TICK, 6'd0, mk_time('0, '0, '0, '0, '0), 32'd0, 8'd0);
    sender_gap();
    send_req(cjtm_pkg::CMD_ADD, 6'd0, ANY_TIME, 32'hFFFF_FFFF, 8'hFF);
    send_req(cjtm_pkg::CMD_ADD, 6'd0, late_time, 32'd0, 8'd0);
    sender_gap();
    send_req(cjtm_pkg::CMD_ADD, 6'd0, mk_time('0, '0, '0, '0, '0), 32'h1234_5678, 8'd1);
    send_req(cjtm_pkg::CMD_ADD, 6'd0, mk_time(7'h3F, '1, '1, '1, '1), 32'hA5A5_5A5A, 8'd2);
    send_req(cjtm_pkg::CMD_TICK, 6'd0, late_time, 32'd0, 8'd0);
    sender_gap();
    send_req(cjtm_pkg::CMD_TICK, 6'd0, mk_time('0, '0, '0, '0, '0), 32'd0, 8'd0);
    send_req(cjtm_pkg::CMD_TICK, 6'd0, mk_time(7'h3F, '0, '0, '0, '0), 32'd0, 8'd0);
    send_req(cjtm_pkg::CMD_TICK, 6'd0, mk_time(7'h40, 6'h20, 6'h20, 5'h10, 4'h8),
             32'd0, 8'd0);
    sender_gap();
    send_req(cjtm_pkg::CMD_TICK, 6'd1, mk_time('0, '0, '0, '0, '0), 32'd0, 8'd0);
    send_req(cjtm_pkg::CMD_TICK, 6'd63, mk_time('0, '0, '0, '0, '0), 32'd0, 8'd0);
    send_req(cjtm_pkg::CMD_NONE, 6'($urandom), random_time(0), $urandom, 8'($urandom));
    send_req(cjtm_pkg::CMD_UNLOAD, 6'd0, ANY_TIME, 32'd0, 8'h55);
    send_req(cjtm_pkg::CMD_UNLOAD, 6'd0, ANY_TIME, 32'd0, 8'd0);
    send_req(cjtm_pkg::CMD_TICK, 6'd0, late_time, 32'd0, 8'd0);
    send_req(cjtm_pkg::CMD_UNLOAD, 6'd0, ANY_TIME, 32'd0, 8'd1);
    send_req(cjtm_pkg::CMD_TICK, 6'd0, mk_time(7'h3F, '0, '0, '0, '0), 32'd0, 8'd0);

    // hold the receiver off and offer four ticks while it is held
    drain_wait();
    hold_req = 1'b1;
    while (!holding) @(negedge clk);
    hold_req = 1'b0;
    repeat (4) send_req(cjtm_pkg::CMD_TICK, 6'd0, mk_time(7'h3F, '0, '0, '0, '0),
                        32'd0, 8'd0);
    drain_wait();

    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 220 && !paused) begin
        drain_wait();
        paused = 1'b1;
      end
      no_idle = (sent >= 300 && sent < 360);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_req(cjtm_pkg::CMD_ADD, 6'($urandom), random_time(1), $urandom, pick_owner());
        sent++;
      end else if (r < 82) begin
        send_req(cjtm_pkg::CMD_TICK,
                 ($urandom_range(0, 99) < 80) ? 6'd0 : 6'($urandom_range(1, 63)),
                 random_time(0), $urandom, pick_owner());
        sent++;
      end else if (r < 94) begin
        send_req(cjtm_pkg::CMD_UNLOAD, 6'($urandom), random_time(0), $urandom,
                 pick_owner());
        sent++;
      end else begin
        send_req(cjtm_pkg::CMD_NONE, 6'($urandom), random_time(0), $urandom,
                 8'($urandom));
      end
      sender_gap();
    end
    no_idle = 1'b0;

    drain_wait();
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
